// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level, project_world_to_screen.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PWS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/pws_pkg.sv =====
// Types, constants and helpers for the world-to-screen projection pipeline.
// No dependencies.
package pws_pkg;

  localparam int CW     = 50;   // clip coordinate width, signed
  localparam int MW     = 50;   // numerator magnitude width
  localparam int DW     = 49;   // divisor magnitude width
  localparam int PW     = 72;   // scaled numerator width
  localparam int QW     = 32;   // quotient bits produced by the divider
  localparam int IDXW   = 3;
  localparam int DATAW  = 64;
  localparam int VPW    = 14;

  localparam logic [IDXW-1:0] REG_ROW0   = 3'd0;
  localparam logic [IDXW-1:0] REG_ROW1   = 3'd1;
  localparam logic [IDXW-1:0] REG_ROW2   = 3'd2;
  localparam logic [IDXW-1:0] REG_ROW3   = 3'd3;
  localparam logic [IDXW-1:0] REG_WIDTH  = 3'd4;
  localparam logic [IDXW-1:0] REG_HEIGHT = 3'd5;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_ndc;
    logic               w_is_zero;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic [3:0][DATAW-1:0] row;
    logic [VPW-1:0]        width;
    logic [VPW-1:0]        height;
  } cfg_t;

  // Numerator magnitudes and signs after the matrix transform.
  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic [DW-1:0]      den;
    logic               wz;
  } num_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] sh;
    logic          sat;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   lane;
    logic [DW-1:0] den;
    logic          wz;
  } div_t;

  function automatic logic signed [15:0] coef(input logic [DATAW-1:0] row,
                                               input int col);
    return $signed(row[16*col +: 16]);
  endfunction

endpackage

// ===== rtl/pws_transform.sv =====
// Matrix transform: products, clip sums, numerators and divisor (3 stages).
// Depends on pws_pkg.
module pws_transform import pws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  in_t  din,
  input  cfg_t cfg,
  output logic vout,
  output num_t dout
);

  logic signed [47:0] prod [4][4];
  logic signed [CW-1:0] clip [4];
  logic signed [31:0] wv [3];
  logic v1, v2;
  logic signed [CW:0] nx, ny, nz;

  assign wv[0] = din.world_x;
  assign wv[1] = din.world_y;
  assign wv[2] = din.world_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= 48'(coef(cfg.row[r], c) * wv[c]);
        end
        // homogeneous w = 1.0 in Q16.16
        prod[r][3] <= 48'($signed({coef(cfg.row[r], 3), 16'h0000}));
      end
      for (int r = 0; r < 4; r++) begin
        clip[r] <= CW'(prod[r][0]) + CW'(prod[r][1]) + CW'(prod[r][2]) + CW'(prod[r][3]);
      end
    end
  end

  always_comb begin
    nx = (CW+1)'(clip[0]) + (CW+1)'(clip[3]);
    ny = (CW+1)'(clip[3]) - (CW+1)'(clip[1]);
    nz = (CW+1)'(clip[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.mag[0] <= MW'(nx[CW] ? -nx : nx);
      dout.mag[1] <= MW'(ny[CW] ? -ny : ny);
      dout.mag[2] <= MW'(nz[CW] ? -nz : nz);
      dout.neg[0] <= nx[CW] ^ clip[3][CW-1];
      dout.neg[1] <= ny[CW] ^ clip[3][CW-1];
      dout.neg[2] <= nz[CW] ^ clip[3][CW-1];
      dout.den    <= DW'(clip[3][CW-1] ? -clip[3] : clip[3]);
      dout.wz     <= (clip[3] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      vout <= v2;
    end
  end

endmodule

// ===== rtl/pws_scale.sv =====
// Viewport scaling of the numerators and divider setup (2 stages).
// Depends on pws_pkg.
module pws_scale import pws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  num_t din,
  input  cfg_t cfg,
  output logic vout,
  output div_t dout
);

  logic [63:0] px, py;
  num_t n4;
  logic v4;
  logic [PW-1:0] p [3];

  always_ff @(posedge clk) begin
    if (en) begin
      px <= 64'(din.mag[0]) * 64'(cfg.width);
      py <= 64'(din.mag[1]) * 64'(cfg.height);
      n4 <= din;
    end
  end

  // times 128 for Q24.8 halving, times 65536 for Q16.16 depth
  always_comb begin
    p[0] = {px, 7'b0, 1'b0} >> 1;
    p[1] = {py, 7'b0, 1'b0} >> 1;
    p[2] = PW'({n4.mag[2], 16'h0000});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // quotient of 2^32 or more can only saturate
        dout.lane[i].sat <= (DW'(p[i][PW-1:QW]) >= n4.den);
        dout.lane[i].rem <= (DW'(p[i][PW-1:QW]) >= n4.den) ? '0 : DW'(p[i][PW-1:QW]);
        dout.lane[i].sh  <= p[i][QW-1:0];
        dout.lane[i].neg <= n4.neg[i];
      end
      dout.den <= n4.den;
      dout.wz  <= n4.wz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v4 <= vin;
      vout <= v4;
    end
  end

endmodule

// ===== rtl/pws_div_step.sv =====
// One restoring division step for the three lanes, registered.
// Depends on pws_pkg.
module pws_div_step import pws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  div_t din,
  output logic vout,
  output div_t dout
);

  logic [DW:0] t [3];
  logic        ge [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]  = {din.lane[i].rem, din.lane[i].sh[QW-1]};
      ge[i] = (t[i] >= {1'b0, din.den});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dout.lane[i].rem <= ge[i] ? DW'(t[i] - {1'b0, din.den}) : DW'(t[i]);
        dout.lane[i].sh  <= {din.lane[i].sh[QW-2:0], ge[i]};
        dout.lane[i].sat <= din.lane[i].sat;
        dout.lane[i].neg <= din.lane[i].neg;
      end
      dout.den <= din.den;
      dout.wz  <= din.wz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

endmodule

// ===== rtl/pws_output.sv =====
// Sign, saturation and zero-w handling into the output register.
// Depends on pws_pkg.
module pws_output import pws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  div_t din,
  output logic vout,
  output out_t dout
);

  logic signed [31:0] val [3];
  logic [2:0] clp;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = '0;
      clp[i] = 1'b0;
      if (!din.wz) begin
        if (din.lane[i].neg) begin
          if (din.lane[i].sat || din.lane[i].sh > 32'h80000000) begin
            val[i] = S32_MIN;
            clp[i] = 1'b1;
          end else begin
            val[i] = $signed(32'h0 - din.lane[i].sh);
          end
        end else begin
          if (din.lane[i].sat || din.lane[i].sh[QW-1]) begin
            val[i] = S32_MAX;
            clp[i] = 1'b1;
          end else begin
            val[i] = $signed(din.lane[i].sh);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.screen_x  <= val[0];
      dout.screen_y  <= val[1];
      dout.depth_ndc <= val[2];
      dout.w_is_zero <= din.wz;
      dout.clamped   <= |clp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

endmodule

// ===== rtl/project_world_to_screen.sv =====
// Top level of the world-to-screen projection pipeline.
// Depends on pws_pkg, pws_transform, pws_scale, pws_div_step, pws_output.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one world point
//   (x, y, z in Q16.16). Output channel out_valid/out_ready/out_data carries
//   screen x and y (Q24.8), depth z/w (Q16.16), a zero-w flag and a
//   saturation flag.
//   Configuration is written through cfg_wen/cfg_index/cfg_data while the
//   pipeline is empty: indexes 0-3 are matrix rows, 4 width, 5 height.
//   The pipeline has three transform stages, two scaling stages,
//   thirty-two restoring divider stages (one quotient bit each) and the
//   output register. Throughput is one request per cycle while not stalled.
//   The whole pipeline advances together; when the output holds a request
//   that is not taken, every stage holds and in_ready drops.
//   Reset empties the pipeline and loads the identity matrix and a
//   1024 x 768 viewport.
module project_world_to_screen import pws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_wen,
  input  logic [IDXW-1:0]  cfg_index,
  input  logic [DATAW-1:0] cfg_data
);

  `include "assert_macros.svh"

  cfg_t cfg;
  logic en;
  logic v3, v5;
  num_t n3;
  div_t dv [QW+1];
  logic vd [QW+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= 64'h0000_0000_0000_1000;
      cfg.row[1] <= 64'h0000_0000_1000_0000;
      cfg.row[2] <= 64'h0000_1000_0000_0000;
      cfg.row[3] <= 64'h1000_0000_0000_0000;
      cfg.width  <= VPW'(1024);
      cfg.height <= VPW'(768);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ROW0:   cfg.row[0] <= cfg_data;
        REG_ROW1:   cfg.row[1] <= cfg_data;
        REG_ROW2:   cfg.row[2] <= cfg_data;
        REG_ROW3:   cfg.row[3] <= cfg_data;
        REG_WIDTH:  cfg.width  <= cfg_data[VPW-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[VPW-1:0];
        default: ;
      endcase
    end
  end

  pws_transform u_transform (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid && in_ready), .din(in_data),
    .cfg(cfg), .vout(v3), .dout(n3)
  );

  pws_scale u_scale (
    .clk(clk), .rst(rst), .en(en), .vin(v3), .din(n3), .cfg(cfg),
    .vout(v5), .dout(dv[0])
  );

  assign vd[0] = v5;

  for (genvar s = 0; s < QW; s++) begin : g_div
    pws_div_step u_step (
      .clk(clk), .rst(rst), .en(en), .vin(vd[s]), .din(dv[s]),
      .vout(vd[s+1]), .dout(dv[s+1])
    );
  end

  pws_output u_output (
    .clk(clk), .rst(rst), .en(en), .vin(vd[QW]), .din(dv[QW]),
    .vout(out_valid), .dout(out_data)
  );

  `PWS_ASSERT(a_zero_w, out_valid && out_data.w_is_zero |-> !out_data.clamped && out_data.screen_x == 0 && out_data.screen_y == 0 && out_data.depth_ndc == 0, "zero w result not cleared")
  `PWS_ASSERT(a_stall, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")
  `PWS_ASSERT(a_clamp, out_valid && out_data.clamped |-> out_data.screen_x == S32_MAX || out_data.screen_x == S32_MIN || out_data.screen_y == S32_MAX || out_data.screen_y == S32_MIN || out_data.depth_ndc == S32_MAX || out_data.depth_ndc == S32_MIN, "clamp flag without saturated value")

endmodule
